// ===== rtl/spq_pkg.sv =====
// sorted priority queue package: sizes, entry and control types, codes
// used by spq_cell and sorted_priority_queue_top; no dependencies
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int TAG_BITS      = 16;
  localparam int IDX_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

  // input kind codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
  } entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// one slot of the sorted queue chain: holds an entry, compares, shifts
// depends on spq_pkg
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occ,
  input  wire logic      left_keep,
  input  wire entry_t    left_data,
  input  wire entry_t    right_data,
  output      logic      keep,
  output      entry_t    data,
  output      entry_t    data_next
);

  // entry stays put while it outranks the new one
  assign keep = occ && (data.prio > ctl.new_entry.prio);

  // insert: hold, take the new entry, or shift down; pop: shift up
  always_comb begin
    priority if (ctl.ins) begin
      priority if (keep) begin
        data_next = data;
      end else if (left_keep) begin
        data_next = ctl.new_entry;
      end else begin
        data_next = left_data;
      end
    end else if (ctl.pop) begin
      data_next = right_data;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// sorted priority queue top: chain of spq_cell slots, fill count, result register
// depends on spq_pkg and spq_cell
//
// usage:
//   input channel (in_valid / in_stall) carries one word per command:
//   kind selects insert or pop, new_priority / new_tag give the entry.
//   output channel (out_valid / out_stall) returns one word per command:
//   status, popped entry, head and tail after the command, and entry_count.
//   the result word is registered and valid in the cycle after the command is taken.
//   one command per cycle while in_stall is low; every slot of the chain compares
//   against the new priority and moves in parallel, so a command finishes
//   in every slot together and the result register is the only stage.
//   when the receiver stalls, the result word holds and in_stall is raised
//   until it is taken; a command is accepted in the same cycle the held
//   word leaves.
//   reset clears the count and the output valid; stored slots are not
//   cleared, only slots below the count are ever read.
`default_nettype none

module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic                     kind,
  input  wire logic [PRIORITY_BITS-1:0] new_priority,
  input  wire logic [TAG_BITS-1:0]      new_tag,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [1:0]               status,
  output      logic [PRIORITY_BITS-1:0] popped_priority,
  output      logic [TAG_BITS-1:0]      popped_tag,
  output      logic [PRIORITY_BITS-1:0] head_priority,
  output      logic [TAG_BITS-1:0]      head_tag,
  output      logic [PRIORITY_BITS-1:0] tail_priority,
  output      logic [TAG_BITS-1:0]      tail_tag,
  output      logic [CNT_W-1:0]         entry_count
);

  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [IDX_W-1:0] tail_idx;
  cell_ctl_t        ctl;
  status_t          status_next;
  entry_t           popped_next;
  entry_t           head_next;
  entry_t           tail_next;
  logic             out_valid_next;

  // result register contents
  status_t          res_status;
  entry_t           res_popped;
  entry_t           res_head;
  entry_t           res_tail;
  logic [CNT_W-1:0] res_count;

  logic   keep      [QUEUE_DEPTH];
  logic   left_keep [QUEUE_DEPTH];
  entry_t data      [QUEUE_DEPTH];
  entry_t data_next [QUEUE_DEPTH];
  entry_t right_data[QUEUE_DEPTH];
  entry_t left_data [QUEUE_DEPTH];

  // handshake: take a word unless the result register is held
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);

  // command to the chain
  always_comb begin
    ctl.ins            = accept && (kind == KIND_INSERT) && !full;
    ctl.pop            = accept && (kind == KIND_POP) && !empty;
    ctl.new_entry.prio = new_priority;
    ctl.new_entry.tag  = new_tag;
  end

  // chain of cells, slot 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_keep[i] = 1'b1;
      assign left_data[i] = ctl.new_entry;
    end else begin : g_mid
      assign left_keep[i] = keep[i-1];
      assign left_data[i] = data[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_data[i] = data[i];
    end else begin : g_notlast
      assign right_data[i] = data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (CNT_W'(i) < fill),
      .left_keep  (left_keep[i]),
      .left_data  (left_data[i]),
      .right_data (right_data[i]),
      .keep       (keep[i]),
      .data       (data[i]),
      .data_next  (data_next[i])
    );
  end

  // count update
  always_comb begin
    priority if (ctl.ins) begin
      fill_next = fill + CNT_W'(1);
    end else if (ctl.pop) begin
      fill_next = fill - CNT_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // result word: status, popped entry, ends after the command
  assign tail_idx = IDX_W'(fill_next - CNT_W'(1));

  always_comb begin
    priority if (kind == KIND_INSERT && full) begin
      status_next = ST_FULL;
    end else if (kind == KIND_POP && empty) begin
      status_next = ST_EMPTY;
    end else begin
      status_next = ST_DONE;
    end
    popped_next = ctl.pop ? data[0] : '0;
    head_next   = (fill_next != '0) ? data_next[0] : '0;
    tail_next   = (fill_next != '0) ? data_next[tail_idx] : '0;
  end

  assign out_valid_next = accept || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      res_popped <= popped_next;
      res_head   <= head_next;
      res_tail   <= tail_next;
      res_count  <= fill_next;
    end
  end

  assign status          = 2'(res_status);
  assign popped_priority = res_popped.prio;
  assign popped_tag      = res_popped.tag;
  assign head_priority   = res_head.prio;
  assign head_tag        = res_head.tag;
  assign tail_priority   = res_tail.prio;
  assign tail_tag        = res_tail.tag;
  assign entry_count     = res_count;

  // checks
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_POP && empty) |=> (res_status == ST_EMPTY && res_count == '0))
    else $error("pop on empty queue not rejected");

  a_ins_head: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_INSERT && !full) |=> (res_head.prio >= $past(new_priority)))
    else $error("head ranks below a just-inserted entry");

  a_head_tail_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_count != '0) |-> (head_priority >= tail_priority))
    else $error("head ranks below tail");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for sorted_priority_queue_top: queued command driver, result monitor, shadow queue
// depends on spq_pkg and the rtl of sorted_priority_queue_top
`timescale 1ns / 1ps

module tb
  import spq_pkg::*;
();

  typedef struct {
    logic                     kind;
    logic [PRIORITY_BITS-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
    int                       gap;
    bit                       drain;
  } command_t;

  typedef struct {
    status_t                  status;
    logic [PRIORITY_BITS-1:0] popped_prio;
    logic [TAG_BITS-1:0]      popped_tag;
    logic [PRIORITY_BITS-1:0] head_prio;
    logic [TAG_BITS-1:0]      head_tag;
    logic [PRIORITY_BITS-1:0] tail_prio;
    logic [TAG_BITS-1:0]      tail_tag;
    logic [CNT_W-1:0]         count;
  } queue_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     kind = KIND_INSERT;
  logic [PRIORITY_BITS-1:0] new_priority = '0;
  logic [TAG_BITS-1:0]      new_tag = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic [PRIORITY_BITS-1:0] popped_priority;
  logic [TAG_BITS-1:0]      popped_tag;
  logic [PRIORITY_BITS-1:0] head_priority;
  logic [TAG_BITS-1:0]      head_tag;
  logic [PRIORITY_BITS-1:0] tail_priority;
  logic [TAG_BITS-1:0]      tail_tag;
  logic [CNT_W-1:0]         entry_count;

  sorted_priority_queue_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .new_priority    (new_priority),
    .new_tag         (new_tag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .popped_priority (popped_priority),
    .popped_tag      (popped_tag),
    .head_priority   (head_priority),
    .head_tag        (head_tag),
    .tail_priority   (tail_priority),
    .tail_tag        (tail_tag),
    .entry_count     (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  command_t    cmd_queue[$];
  queue_word_t expected_words[$];
  int          errors = 0;

  // shadow copy of the sorted slots, slot 0 is the head
  entry_t      shadow_slots[QUEUE_DEPTH];
  int          shadow_fill = 0;

  function automatic queue_word_t serve_command(command_t c);
    queue_word_t w;
    int          pos;
    int          i;
    w.status      = ST_DONE;
    w.popped_prio = '0;
    w.popped_tag  = '0;
    if (c.kind == KIND_INSERT) begin
      if (shadow_fill >= QUEUE_DEPTH) begin
        w.status = ST_FULL;
      end else begin
        // behind every strictly greater priority, ahead of equal ones
        pos = 0;
        while (pos < shadow_fill && shadow_slots[pos].prio > c.prio) pos++;
        for (i = shadow_fill; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos].prio = c.prio;
        shadow_slots[pos].tag  = c.tag;
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) begin
        w.status = ST_EMPTY;
      end else begin
        w.popped_prio = shadow_slots[0].prio;
        w.popped_tag  = shadow_slots[0].tag;
        for (i = 1; i < shadow_fill; i++) shadow_slots[i-1] = shadow_slots[i];
        shadow_fill--;
      end
    end
    // head and tail read as zero on an empty queue
    if (shadow_fill > 0) begin
      w.head_prio = shadow_slots[0].prio;
      w.head_tag  = shadow_slots[0].tag;
      w.tail_prio = shadow_slots[shadow_fill-1].prio;
      w.tail_tag  = shadow_slots[shadow_fill-1].tag;
    end else begin
      w.head_prio = '0;
      w.head_tag  = '0;
      w.tail_prio = '0;
      w.tail_tag  = '0;
    end
    w.count = CNT_W'(shadow_fill);
    return w;
  endfunction

  task automatic add_cmd(logic k, int prio, int tag, int gap, bit drain);
    command_t c;
    c.kind  = k;
    c.prio  = PRIORITY_BITS'(prio);
    c.tag   = TAG_BITS'(tag);
    c.gap   = gap;
    c.drain = drain;
    cmd_queue.push_back(c);
  endtask

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp, act);
      errors++;
    end
  endtask

  // driver: one word held on the input until taken
  command_t cur_cmd;
  bit       have_cur = 1'b0;
  int       gap_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      have_cur = 1'b0;
      gap_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(serve_command(cur_cmd));
        have_cur = 1'b0;
      end
      if (!have_cur && cmd_queue.size() > 0) begin
        if (cmd_queue[0].drain && (expected_words.size() > 0 || in_valid)) begin
          // hold off until every outstanding result word is back
        end else if (gap_count < cmd_queue[0].gap) begin
          gap_count++;
        end else begin
          cur_cmd = cmd_queue.pop_front();
          have_cur = 1'b1;
          gap_count = 0;
        end
      end
      if (have_cur) begin
        in_valid     <= 1'b1;
        kind         <= cur_cmd.kind;
        new_priority <= cur_cmd.prio;
        new_tag      <= cur_cmd.tag;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each taken result word, random stall between words
  int stall_left = 0;
  int words_seen = 0;

  always @(posedge clk) begin
    queue_word_t w;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected result word status %0d count %0d", $time, status,
                   entry_count);
          errors++;
        end else begin
          w = expected_words.pop_front();
          check_field("status", w.status, status);
          check_field("popped_priority", w.popped_prio, popped_priority);
          check_field("popped_tag", w.popped_tag, popped_tag);
          check_field("head_priority", w.head_prio, head_priority);
          check_field("head_tag", w.head_tag, head_tag);
          check_field("tail_priority", w.tail_prio, tail_priority);
          check_field("tail_tag", w.tail_tag, tail_tag);
          check_field("entry_count", w.count, entry_count);
        end
        words_seen++;
        // quiet stretch with no stalls every so often
        stall_left = ((words_seen % 128) >= 96) ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int  n;
    int  k;
    int  phase_len;
    int  mode;
    int  ins_pct;
    bit  calm;
    int  prio;
    int  gap;

    // directed: empty pop, extremes, equal priorities at head, middle and tail
    add_cmd(KIND_POP, 0, 0, 0, 1'b0);
    add_cmd(KIND_INSERT, 255, 16'hffff, 0, 1'b0);
    add_cmd(KIND_INSERT, 0, 16'h0000, 1, 1'b0);
    add_cmd(KIND_INSERT, 128, 16'h1111, 0, 1'b0);
    add_cmd(KIND_INSERT, 128, 16'h2222, 0, 1'b0);
    add_cmd(KIND_INSERT, 128, 16'h3333, 2, 1'b0);
    add_cmd(KIND_INSERT, 0, 16'h4444, 0, 1'b0);
    add_cmd(KIND_INSERT, 255, 16'h5555, 0, 1'b0);
    for (k = 0; k < 7; k++) add_cmd(KIND_POP, 255, 16'hffff, k % 3, 1'b0);
    add_cmd(KIND_POP, 0, 0, 0, 1'b0);
    add_cmd(KIND_INSERT, 1, 16'haaaa, 0, 1'b1);
    add_cmd(KIND_INSERT, 254, 16'h5555, 0, 1'b0);
    add_cmd(KIND_POP, 0, 0, 0, 1'b0);
    add_cmd(KIND_POP, 0, 0, 0, 1'b0);

    // random phases biased toward filling, draining or mixed traffic
    n = 0;
    while (n < 600) begin
      phase_len = $urandom_range(20, 50);
      mode      = $urandom_range(0, 2);
      calm      = ($urandom_range(0, 3) == 0);
      ins_pct   = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      for (k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 1) == 0) prio = $urandom_range(0, 3) * 85;
        else prio = $urandom_range(0, 255);
        gap = calm ? 0 : $urandom_range(0, 9);
        add_cmd(($urandom_range(1, 100) <= ins_pct) ? KIND_INSERT : KIND_POP, prio,
                $urandom_range(0, 65535), gap, (n % 150) == 149);
        n++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() > 0 || have_cur || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
